@@ rtl/sus_pkg.sv @@
// Shared types and constants for the subduction uplift sample pipeline.
// No dependencies.
package sus_pkg;

    localparam int unsigned DIV_BITS  = 16;
    localparam int unsigned REM_W     = 19;
    localparam logic [15:0] PEAK_DIST = 16'd7200;
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [17:0] THREE_Q16 = 18'd196608;

    localparam logic [15:0] RST_TIME_STEP  = 16'd256;
    localparam logic [15:0] RST_REACH      = 16'd28800;
    localparam logic [15:0] RST_MAX_SPEED  = 16'd25600;
    localparam logic [16:0] RST_TRENCH     = 17'h16000;
    localparam logic [16:0] RST_MAX_ELEV   = 17'd40960;
    localparam logic [23:0] RST_RATE       = 24'd10066;

    typedef enum logic [2:0] {
        REG_TIME_STEP   = 3'd0,
        REG_FRONT_REACH = 3'd1,
        REG_MAX_SPEED   = 3'd2,
        REG_TRENCH      = 3'd3,
        REG_MAX_ELEV    = 3'd4,
        REG_RATE        = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [REM_W-1:0]    den;
        logic [DIV_BITS-1:0] q;
    } t_lane;

    typedef struct packed {
        logic        fd_zero;
        logic        rising;
        logic        gv_zero;
        logic        gv_full;
        logic        hz_zero;
        logic        hz_full;
        logic [16:0] elev;
    } t_side;

endpackage

@@ rtl/subduction_uplift_sample.sv @@
// Subduction uplift of one crust sample: 24-stage pipeline with bit-per-stage dividers.
// Depends on sus_pkg.
//
//  channel | handshake                 | payload
//  request | start, busy (always low)  | i_front_distance .. i_sample_elevation
//  result  | o_valid, one-cycle strobe | o_new_elevation, o_applied_uplift, o_andean_mark
//  config  | APB psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// One request per cycle.
// The stages are the input register, 16 divider stages shared by the three quotients,
// six arithmetic stages and the output register.
// Synchronous active-low reset clears only the valid bits and loads the config registers with their RST_* defaults.
// Nothing stalls: busy is held low.
module subduction_uplift_sample
    import sus_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_front_distance,
    input  logic        i_eligible,
    input  logic signed [16:0] i_relative_speed,
    input  logic signed [16:0] i_incoming_elevation,
    input  logic signed [16:0] i_sample_elevation,
    output logic        o_valid,
    output logic signed [16:0] o_new_elevation,
    output logic [23:0] o_applied_uplift,
    output logic        o_andean_mark,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_time_step, r_reach, r_max_speed;
    logic [16:0] r_trench, r_max_elev;
    logic [23:0] r_rate;
    logic [2:0]  cfg_idx;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= RST_TIME_STEP;
            r_reach     <= RST_REACH;
            r_max_speed <= RST_MAX_SPEED;
            r_trench    <= RST_TRENCH;
            r_max_elev  <= RST_MAX_ELEV;
            r_rate      <= RST_RATE;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_idx)
                REG_TIME_STEP:   r_time_step <= pwdata[15:0];
                REG_FRONT_REACH: r_reach     <= pwdata[15:0];
                REG_MAX_SPEED:   r_max_speed <= pwdata[15:0];
                REG_TRENCH:      r_trench    <= pwdata[16:0];
                REG_MAX_ELEV:    r_max_elev  <= pwdata[16:0];
                REG_RATE:        r_rate      <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_TIME_STEP:   prdata = {16'd0, r_time_step};
            REG_FRONT_REACH: prdata = {16'd0, r_reach};
            REG_MAX_SPEED:   prdata = {16'd0, r_max_speed};
            REG_TRENCH:      prdata = {{15{r_trench[16]}}, r_trench};
            REG_MAX_ELEV:    prdata = {{15{r_max_elev[16]}}, r_max_elev};
            REG_RATE:        prdata = {8'd0, r_rate};
            default:         prdata = 32'd0;
        endcase
    end

    // request decode
    logic        acc;
    logic        n_rising;
    logic signed [17:0] hz_num, hz_den;
    t_side       n_side;
    t_lane       n_lane [0:2];

    assign acc = start && !busy;

    always_comb begin
        n_rising = i_front_distance < PEAK_DIST;
        hz_num = 18'(i_incoming_elevation) - 18'($signed(r_trench));
        hz_den = 18'($signed(r_max_elev)) - 18'($signed(r_trench));

        n_side.fd_zero = !i_eligible || (i_front_distance == 16'd0)
                         || (i_front_distance >= r_reach);
        n_side.rising  = n_rising;
        n_side.gv_zero = i_relative_speed[16] || (i_relative_speed == 17'sd0);
        n_side.gv_full = i_relative_speed[15:0] >= r_max_speed;
        n_side.hz_zero = (hz_den <= 18'sd0) || (hz_num <= 18'sd0);
        n_side.hz_full = hz_num >= hz_den;
        n_side.elev    = i_sample_elevation;

        n_lane[0].rem = n_rising ? REM_W'(i_front_distance)
                                 : REM_W'(i_front_distance - PEAK_DIST);
        n_lane[0].den = n_rising ? REM_W'(PEAK_DIST) : REM_W'(r_reach - PEAK_DIST);
        n_lane[0].q   = '0;
        n_lane[1].rem = REM_W'(i_relative_speed[15:0]);
        n_lane[1].den = REM_W'(r_max_speed);
        n_lane[1].q   = '0;
        n_lane[2].rem = REM_W'(hz_num[16:0]);
        n_lane[2].den = REM_W'(hz_den[16:0]);
        n_lane[2].q   = '0;
    end

    t_lane r_div  [0:DIV_BITS][0:2];
    t_lane n_step [0:DIV_BITS-1][0:2];
    t_side r_sd   [0:DIV_BITS];
    logic  r_vld  [0:DIV_BITS];

    always_comb begin
        logic [REM_W-1:0] sh;
        for (int k = 0; k < int'(DIV_BITS); k++) begin
            for (int l = 0; l < 3; l++) begin
                sh = {r_div[k][l].rem[REM_W-2:0], 1'b0};
                n_step[k][l].den = r_div[k][l].den;
                if (sh >= r_div[k][l].den) begin
                    n_step[k][l].rem = sh - r_div[k][l].den;
                    n_step[k][l].q   = {r_div[k][l].q[DIV_BITS-2:0], 1'b1};
                end else begin
                    n_step[k][l].rem = sh;
                    n_step[k][l].q   = {r_div[k][l].q[DIV_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= int'(DIV_BITS); k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= acc;
            for (int k = 0; k < int'(DIV_BITS); k++) r_vld[k+1] <= r_vld[k];
        end
        r_sd[0] <= n_side;
        for (int l = 0; l < 3; l++) r_div[0][l] <= n_lane[l];
        for (int k = 0; k < int'(DIV_BITS); k++) begin
            r_sd[k+1] <= r_sd[k];
            for (int l = 0; l < 3; l++) r_div[k+1][l] <= n_step[k][l];
        end
    end

    // stage A: squares and speed factor
    t_side       r_a_sd;
    logic        r_a_vld;
    logic [15:0] r_a_t, r_a_t2;
    logic [16:0] r_a_gv, r_a_hz;
    logic [16:0] zt;
    logic [33:0] zt_sq;
    logic [31:0] t_sq;

    assign zt    = r_sd[DIV_BITS].hz_full ? ONE_Q16 : {1'b0, r_div[DIV_BITS][2].q};
    assign zt_sq = 34'(zt) * 34'(zt);
    assign t_sq  = 32'(r_div[DIV_BITS][0].q) * 32'(r_div[DIV_BITS][0].q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else          r_a_vld <= r_vld[DIV_BITS];
        r_a_sd <= r_sd[DIV_BITS];
        r_a_t  <= r_div[DIV_BITS][0].q;
        r_a_t2 <= t_sq[31:16];
        r_a_hz <= r_sd[DIV_BITS].hz_zero ? 17'd0 : zt_sq[32:16];
        if (r_sd[DIV_BITS].gv_zero)      r_a_gv <= 17'd0;
        else if (r_sd[DIV_BITS].gv_full) r_a_gv <= ONE_Q16;
        else                             r_a_gv <= {1'b0, r_div[DIV_BITS][1].q};
    end

    // stage B: smoothstep and distance factor
    logic        r_b_vld;
    logic [16:0] r_b_elev, r_b_fd, r_b_gv, r_b_hz;
    logic [17:0] w;
    logic [33:0] s_prod;
    logic [16:0] s;

    assign w      = THREE_Q16 - {1'b0, r_a_t, 1'b0};
    assign s_prod = 34'(r_a_t2) * 34'(w);
    assign s      = {1'b0, s_prod[31:16]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_vld <= 1'b0;
        else          r_b_vld <= r_a_vld;
        r_b_elev <= r_a_sd.elev;
        r_b_gv   <= r_a_gv;
        r_b_hz   <= r_a_hz;
        if (r_a_sd.fd_zero)     r_b_fd <= 17'd0;
        else if (r_a_sd.rising) r_b_fd <= s;
        else                    r_b_fd <= ONE_Q16 - s;
    end

    // stages C..F: multiply chain
    logic        r_c_vld, r_d_vld, r_e_vld, r_f_vld;
    logic [16:0] r_c_elev, r_d_elev, r_e_elev, r_f_elev;
    logic [16:0] r_c_gv, r_c_hz, r_d_hz;
    logic [23:0] r_c_up, r_d_up, r_e_up, r_f_up;
    logic [40:0] p_c, p_d, p_e;
    logic [39:0] p_f;

    assign p_c = 41'(r_rate) * 41'(r_b_fd);
    assign p_d = 41'(r_c_up) * 41'(r_c_gv);
    assign p_e = 41'(r_d_up) * 41'(r_d_hz);
    assign p_f = 40'(r_e_up) * 40'(r_time_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
        r_c_elev <= r_b_elev;
        r_d_elev <= r_c_elev;
        r_e_elev <= r_d_elev;
        r_f_elev <= r_e_elev;
        r_c_gv   <= r_b_gv;
        r_c_hz   <= r_b_hz;
        r_d_hz   <= r_c_hz;
        r_c_up   <= p_c[39:16];
        r_d_up   <= p_d[39:16];
        r_e_up   <= p_e[39:16];
        r_f_up   <= (|p_f[39:32]) ? 24'hFFFFFF : p_f[31:8];
    end

    // output stage: elevation and cap
    logic signed [17:0] sum, cap;
    assign cap = 18'($signed(r_max_elev));
    assign sum = 18'($signed(r_f_elev)) + $signed({6'd0, r_f_up[23:12]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_f_vld;
        o_applied_uplift <= r_f_up;
        o_andean_mark    <= r_f_up != 24'd0;
        if (r_f_up == 24'd0)  o_new_elevation <= r_f_elev;
        else if (sum > cap)   o_new_elevation <= r_max_elev;
        else                  o_new_elevation <= sum[16:0];
    end

endmodule

@@ rtl/sus_checker.sv @@
// Port-level checks for subduction_uplift_sample, bound to the top level.
// Depends on subduction_uplift_sample ports only.
module sus_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        pready,
    input logic        o_valid,
    input logic [23:0] o_applied_uplift,
    input logic        o_andean_mark
);

    a_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_andean_mark == (o_applied_uplift != 24'd0)))
        else $error("mark disagrees with uplift");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

endmodule

bind subduction_uplift_sample sus_checker u_sus_checker (.*);
